// ===== design/sdtt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdtt_pkg
// Shared types and constants of the signed decimal to text converter.
// ----------------------------------------------------------------------------
package sdtt_pkg;

   // Magnitude of a 64-bit value needs at most 20 decimal digits
   localparam int VALUE_W   = 64;
   localparam int NUM_BCD   = 20;
   localparam int BCD_IDX_W = $clog2(NUM_BCD);
   localparam int CNT_W     = $clog2(VALUE_W);

   // ASCII codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIZE,
      ST_EMIT
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;     // capture a new item
      logic shift;    // one double-dabble step
      logic size;     // work out digit count and field span
      logic advance;  // step to the next character
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic shift_done;  // current shift is the final one
      logic final_char;  // character on the output is the last one
   } dp_sts_type;

endpackage
`default_nettype wire

// ===== design/signed_decimal_to_text.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_decimal_to_text
// Converts a signed 64-bit value to printf-style decimal text, one ASCII
// character per output transfer, most significant character first.
//
//   Channel  Dir  Payload                                         Framing
//   req_*    in   tdata: value, sign_char, min_digits,            none
//                 field_width, left_justify, zero_pad
//   rsp_*    out  tdata: text_char                                tlast = last
//
// Sequence: an item is accepted, the double-dabble shift loop runs over all
// 64 magnitude bits (one magnitude bit a cycle), the field is sized, and then
// the characters go out one by one while rsp_tready is high.
// Reset clears only the sequencer; no clearing pass is needed.
// Output stalls hold the current character; no new item is taken until the
// last character of the current one has been transferred.
// ----------------------------------------------------------------------------
module signed_decimal_to_text #(
   parameter int MAX_FIELD = 63
) (
   input  wire              clock,
   input  wire              reset,
   // [63:0] value, [71:64] sign_char, [77:72] min_digits,
   // [83:78] field_width, [84] left_justify, [85] zero_pad, [87:86] zero
   input  wire logic [87:0] req_tdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] text_char
   output logic [7:0]       rsp_tdata,
   output logic             rsp_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready
);
   import sdtt_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Sequencer
   sdtt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Conversion datapath
   sdtt_datapath #(
      .MAX_FIELD (MAX_FIELD)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .sts          (sts),
      .value        (req_tdata[63:0]),
      .sign_char    (req_tdata[71:64]),
      .min_digits   (req_tdata[77:72]),
      .field_width  (req_tdata[83:78]),
      .left_justify (req_tdata[84]),
      .zero_pad     (req_tdata[85]),
      .text_char    (rsp_tdata),
      .last         (rsp_tlast)
   );

endmodule
`default_nettype wire

// ===== design/sdtt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdtt_datapath
// Magnitude, binary to BCD shift register, field sizing and character select.
// ----------------------------------------------------------------------------
module sdtt_datapath #(
   parameter int MAX_FIELD = 63
) (
   input  wire                        clock,
   input  wire sdtt_pkg::dp_cmd_type  cmd,
   output sdtt_pkg::dp_sts_type       sts,
   input  wire logic [63:0]           value,
   input  wire logic [7:0]            sign_char,
   input  wire logic [5:0]            min_digits,
   input  wire logic [5:0]            field_width,
   input  wire logic                  left_justify,
   input  wire logic                  zero_pad,
   output logic      [7:0]            text_char,
   output logic                       last
);
   import sdtt_pkg::*;

   localparam int SPAN_W = $clog2(MAX_FIELD + 1);

   logic [VALUE_W-1:0]             mag_ff, mag_in;
   logic [NUM_BCD-1:0][3:0]        bcd_ff, bcd_in;
   logic [NUM_BCD-1:0][3:0]        bcd_adj;
   logic [NUM_BCD*4-1:0]           bcd_flat;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [7:0]                     lead_ff, lead_in;
   logic                           has_sign_ff, has_sign_in;
   logic [SPAN_W-1:0]              prec_ff, prec_in;
   logic [SPAN_W-1:0]              width_ff, width_in;
   logic                           left_ff, left_in;
   logic                           zpad_ff, zpad_in;
   logic                           sign_pend_ff, sign_pend_in;
   logic [SPAN_W-1:0]              pos_ff, pos_in;
   logic [BCD_IDX_W:0]             ndig;
   logic [SPAN_W:0]                span_a, span, sum_sign, width_ext, prec_ext;
   logic [3:0]                     digit;

   // Add 3 to every BCD digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_BCD; i++) begin
         bcd_adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
   end

   assign bcd_flat = bcd_adj;

   // Count significant digits; zero still has one
   always_comb begin
      ndig = (BCD_IDX_W+1)'(1);
      for (int i = 0; i < NUM_BCD; i++) begin
         if (bcd_ff[i] != 4'd0) begin
            ndig = (BCD_IDX_W+1)'(i + 1);
         end
      end
   end

   // Field span: digits, raised to precision, raised to zero-pad width
   always_comb begin
      prec_ext  = {1'b0, prec_ff};
      width_ext = {1'b0, width_ff};
      span_a    = ((SPAN_W+1)'(ndig) > prec_ext) ? (SPAN_W+1)'(ndig) : prec_ext;
      sum_sign  = span_a + (SPAN_W+1)'(has_sign_ff);
      span      = span_a;
      if (!left_ff && zpad_ff && (prec_ff == '0) && (sum_sign < width_ext)) begin
         span = width_ext - (SPAN_W+1)'(has_sign_ff);
      end
   end

   // Next state of the datapath registers
   always_comb begin
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      cnt_in       = cnt_ff;
      lead_in      = lead_ff;
      has_sign_in  = has_sign_ff;
      prec_in      = prec_ff;
      width_in     = width_ff;
      left_in      = left_ff;
      zpad_in      = zpad_ff;
      sign_pend_in = sign_pend_ff;
      pos_in       = pos_ff;
      if (cmd.load) begin
         mag_in      = value[VALUE_W-1] ? (~value + 64'd1) : value;
         bcd_in      = '0;
         cnt_in      = '0;
         lead_in     = value[VALUE_W-1] ? CHAR_MINUS : sign_char;
         has_sign_in = value[VALUE_W-1] || (sign_char != 8'd0);
         prec_in     = (int'(min_digits) > MAX_FIELD) ? SPAN_W'(MAX_FIELD)
                                                      : SPAN_W'(min_digits);
         width_in    = (int'(field_width) > MAX_FIELD) ? SPAN_W'(MAX_FIELD)
                                                       : SPAN_W'(field_width);
         left_in     = left_justify;
         zpad_in     = zero_pad;
      end
      if (cmd.shift) begin
         bcd_in = {bcd_flat[NUM_BCD*4-2:0], mag_ff[VALUE_W-1]};
         mag_in = {mag_ff[VALUE_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
      end
      if (cmd.size) begin
         pos_in       = SPAN_W'(span - (SPAN_W+1)'(1));
         sign_pend_in = has_sign_ff;
      end
      if (cmd.advance) begin
         if (sign_pend_ff) begin
            sign_pend_in = 1'b0;
         end else begin
            pos_in = pos_ff - SPAN_W'(1);
         end
      end
   end

   // Hold all payload registers between commands
   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      bcd_ff       <= bcd_in;
      cnt_ff       <= cnt_in;
      lead_ff      <= lead_in;
      has_sign_ff  <= has_sign_in;
      prec_ff      <= prec_in;
      width_ff     <= width_in;
      left_ff      <= left_in;
      zpad_ff      <= zpad_in;
      sign_pend_ff <= sign_pend_in;
      pos_ff       <= pos_in;
   end

   // Positions above the BCD register are leading zeros
   always_comb begin
      digit = 4'd0;
      if (pos_ff < SPAN_W'(NUM_BCD)) begin
         digit = bcd_ff[pos_ff[BCD_IDX_W-1:0]];
      end
   end

   assign text_char      = sign_pend_ff ? lead_ff : (CHAR_ZERO | {4'd0, digit});
   assign last           = !sign_pend_ff && (pos_ff == '0);
   assign sts.shift_done = (cnt_ff == {CNT_W{1'b1}});
   assign sts.final_char = last;

endmodule
`default_nettype wire

// ===== design/sdtt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdtt_ctrl
// Sequencer: accept an item, run the BCD conversion, size, emit characters.
// ----------------------------------------------------------------------------
module sdtt_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output sdtt_pkg::dp_cmd_type       cmd,
   input  wire sdtt_pkg::dp_sts_type  sts
);
   import sdtt_pkg::*;

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
            if (sts.shift_done) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               cmd.advance = 1'b1;
               if (sts.final_char) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // One item at a time: no intake while characters are going out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while output active");

   // Accepted item starts the conversion
   a_accept_convert: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_CONVERT))
      else $error("accepted item did not start conversion");

   // A non-final transfer is followed by another character
   a_keep_emitting: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !sts.final_char) |=> rsp_tvalid)
      else $error("character stream stopped before last");

   // The final transfer ends the item
   a_end_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && sts.final_char) |=> req_tready)
      else $error("block not idle after last character");

endmodule
`default_nettype wire

// ===== sim/decimal_text_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_text_checker
// Watches both streams of the signed decimal to text converter. Every
// accepted request is expanded into the characters it must produce. Every
// character transfer is then compared against the oldest of them.
// ----------------------------------------------------------------------------
module decimal_text_checker #(
   parameter int MAX_FIELD = 63
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // [63:0] value, [71:64] sign_char, [77:72] min_digits,
   // [83:78] field_width, [84] left_justify, [85] zero_pad, [87:86] zero
   input  wire logic [87:0] req_tdata,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   // [7:0] text_char
   input  wire logic [7:0]  rsp_tdata,
   input  wire logic        rsp_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output int               fail_count,
   output int               chars_pending,
   output int               chars_checked
);
   import sdtt_pkg::*;

   // Request fields in tdata order, first field in the low bits
   typedef struct packed {
      logic [1:0] unused;
      logic       zero_pad;
      logic       left_justify;
      logic [5:0] field_width;
      logic [5:0] min_digits;
      logic [7:0] sign_char;
      logic [63:0] value;
   } conversion_req_type;

   typedef struct {
      logic [7:0] text_char;
      logic       last;
   } text_beat_type;

   text_beat_type expected_text[$];

   // Expand one request into its text, sign first, then the digits
   function automatic void predict_decimal_text(input conversion_req_type r);
      logic          is_neg;
      logic [63:0]   mag;
      logic [63:0]   rest;
      logic [7:0]    lead;
      logic [7:0]    digits [64];
      int            has_sign;
      int            prec;
      int            width;
      int            ndig;
      int            span;
      int            k;
      text_beat_type beat;
      is_neg = r.value[63];
      // two's complement negate also covers the most negative value
      mag    = is_neg ? (~r.value + 64'd1) : r.value;
      lead   = is_neg ? CHAR_MINUS : r.sign_char;
      has_sign = (lead != 8'd0) ? 1 : 0;
      prec  = (int'(r.min_digits) > MAX_FIELD) ? MAX_FIELD : int'(r.min_digits);
      width = (int'(r.field_width) > MAX_FIELD) ? MAX_FIELD : int'(r.field_width);
      ndig = 1;
      rest = mag;
      while (rest >= 64'd10) begin
         rest = rest / 64'd10;
         ndig++;
      end
      span = (ndig < prec) ? prec : ndig;
      // zero fill to the width only when no precision is given
      if (!r.left_justify && r.zero_pad && prec == 0 && span < width - has_sign)
         span = width - has_sign;
      rest = mag;
      for (k = span - 1; k >= 0; k--) begin
         digits[k] = CHAR_ZERO + 8'(rest % 64'd10);
         rest = rest / 64'd10;
      end
      if (has_sign != 0) begin
         beat.text_char = lead;
         beat.last      = 1'b0;
         expected_text.push_back(beat);
      end
      for (k = 0; k < span; k++) begin
         beat.text_char = digits[k];
         beat.last      = (k == span - 1);
         expected_text.push_back(beat);
      end
   endfunction

   // Predict on request transfers, compare on character transfers
   always @(posedge clock) begin
      text_beat_type want;
      if (reset) begin
         fail_count    = 0;
         chars_pending = 0;
         chars_checked = 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_decimal_text(conversion_req_type'(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_text.size() == 0) begin
               $error("text_char unexpected: nothing expected, actual 0x%02h", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_text.pop_front();
               chars_checked++;
               if (rsp_tdata !== want.text_char) begin
                  $error("text_char mismatch: expected 0x%02h, actual 0x%02h",
                         want.text_char, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last mismatch: expected %0b, actual %0b", want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
         chars_pending = expected_text.size();
      end
   end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the signed decimal to text converter. Drives directed edge
// cases and then random conversions under several idle and stall mixes,
// with one long output hold-off; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int         IDLE_LIMIT      = 5000;
   localparam int         HOLDOFF_CYCLES  = 400;
   localparam int         ITEMS_PER_PHASE = 98;
   localparam int         DRAIN_CYCLES    = 200;
   localparam logic [7:0] CHAR_PLUS       = 8'h2B;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;

   logic        clock;
   logic        reset;
   logic [87:0] req_tdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;

   int fail_count;
   int chars_pending;
   int chars_checked;
   int items_sent;
   int send_idle_pct;
   int recv_stall_pct;
   int holdoff_requests;
   int idle_cycles;

   signed_decimal_to_text i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   decimal_text_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .fail_count    (fail_count),
      .chars_pending (chars_pending),
      .chars_checked (chars_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Receiver: random stalls, plus a long hold-off on request
   initial begin
      int holdoff_seen;
      int holdoff_left;
      holdoff_seen = 0;
      holdoff_left = 0;
      rsp_tready   = 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_requests != holdoff_seen) begin
            holdoff_seen = holdoff_requests;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [87:0] pack_request(input logic [63:0] value,
                                                input logic [7:0] sign_char,
                                                input logic [5:0] min_digits,
                                                input logic [5:0] field_width,
                                                input logic left_justify,
                                                input logic zero_pad);
      return {2'b00, zero_pad, left_justify, field_width, min_digits, sign_char, value};
   endfunction

   // Random conversion spread over all digit counts and spec mixes
   function automatic logic [87:0] random_request();
      logic [63:0] value;
      logic [7:0]  sign_char;
      logic [5:0]  min_digits;
      if ($urandom_range(9) == 0)
         value = {$urandom, $urandom};
      else
         value = {$urandom, $urandom} >> $urandom_range(63);
      if ($urandom_range(1) == 1)
         value = -value;
      case ($urandom_range(3))
         0: sign_char = 8'd0;
         1: sign_char = CHAR_PLUS;
         2: sign_char = CHAR_SPACE;
         default: sign_char = 8'($urandom);
      endcase
      min_digits = ($urandom_range(1) == 1) ? 6'd0 : 6'($urandom_range(63));
      return pack_request(value, sign_char, min_digits, 6'($urandom_range(63)),
                          1'($urandom), 1'($urandom));
   endfunction

   // Offer one request, with random idle cycles ahead of it
   task automatic send_conversion(input logic [87:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= data;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // Stop offering and wait for every expected character
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (chars_pending != 0);
      @(posedge clock);
   endtask

   initial begin
      req_tdata        = '0;
      req_tvalid       = 1'b0;
      reset            = 1'b1;
      items_sent       = 0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      holdoff_requests = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed edge cases
      send_conversion(pack_request(64'd0, 8'd0, 6'd0, 6'd0, 1'b0, 1'b0));
      send_conversion(pack_request(64'd0, CHAR_PLUS, 6'd0, 6'd0, 1'b0, 1'b0));
      send_conversion(pack_request(64'h7FFF_FFFF_FFFF_FFFF, 8'd0, 6'd0, 6'd0, 1'b0, 1'b0));
      send_conversion(pack_request(64'h8000_0000_0000_0000, 8'd0, 6'd0, 6'd0, 1'b0, 1'b0));
      // most negative with a requested sign, zero filled to full width
      send_conversion(pack_request(64'h8000_0000_0000_0000, CHAR_PLUS, 6'd0, 6'd63,
                                   1'b0, 1'b1));
      send_conversion(pack_request(-64'sd1, 8'd0, 6'd63, 6'd0, 1'b0, 1'b0));
      send_conversion(pack_request(64'd1, CHAR_SPACE, 6'd63, 6'd63, 1'b0, 1'b1));
      send_conversion(pack_request(64'd123, 8'd0, 6'd0, 6'd63, 1'b0, 1'b1));
      // left justify disables zero fill
      send_conversion(pack_request(64'd123, 8'd0, 6'd0, 6'd63, 1'b1, 1'b1));
      // precision takes over from the width
      send_conversion(pack_request(64'd123, 8'd0, 6'd5, 6'd20, 1'b0, 1'b1));
      // precision below the digit count
      send_conversion(pack_request(64'd123456, 8'd0, 6'd2, 6'd0, 1'b0, 1'b0));
      send_conversion(pack_request(-64'sd42, CHAR_PLUS, 6'd0, 6'd3, 1'b0, 1'b1));
      send_conversion(pack_request(-64'sd42, 8'd0, 6'd0, 6'd2, 1'b0, 1'b1));
      // width without zero pad has no effect
      send_conversion(pack_request(64'd42, 8'd0, 6'd0, 6'd30, 1'b0, 1'b0));
      send_conversion(pack_request(64'd0, CHAR_SPACE, 6'd0, 6'd63, 1'b0, 1'b1));
      send_conversion(pack_request(64'd42, 8'hFF, 6'd0, 6'd0, 1'b0, 1'b0));
      send_conversion(pack_request(64'h5555_5555_5555_5555, 8'hAA, 6'd42, 6'd21,
                                   1'b1, 1'b1));
      send_conversion(pack_request(64'hAAAA_AAAA_AAAA_AAAA, 8'h55, 6'd21, 6'd42,
                                   1'b0, 1'b1));
      send_conversion(pack_request(64'd1000000000000000000, 8'd0, 6'd0, 6'd0, 1'b0, 1'b0));
      send_conversion(pack_request(64'd999999999999999999, 8'd0, 6'd0, 6'd0, 1'b0, 1'b0));
      send_conversion(pack_request(64'd0, 8'd0, 6'd1, 6'd1, 1'b1, 1'b1));
      drain_results();

      // Random conversions, one idle mix per phase
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // long output hold-off while requests keep coming
            if (phase == 0 && n == 10)
               holdoff_requests++;
            send_conversion(random_request());
         end
         drain_results();
      end

      // Let any stray output show up before the verdict
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Ran %0d conversions (directed edge cases, then random), %0d characters checked",
               items_sent, chars_checked);
      $display("Idle mixes: none, sender 82%%, receiver 82%%, both 31%%; one long output hold-off");
      if (fail_count == 0 && chars_pending == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
